// ----- src/e2e_pkg.sv -----
package e2e_pkg;

  localparam int DEF_COORD_BITS = 40;
  localparam int DEF_ANGLE_BITS = 32;

  localparam int Q_W   = 32;
  localparam int ST_W  = 37;
  localparam int IN_W  = 38;
  localparam int OUT_W = 39;
  localparam int CFG_W = 33;
  localparam int IDX_W = 3;

  localparam int CORDIC_ITERS = 30;

  localparam logic [IDX_W-1:0] REG_LAT = 3'd0;
  localparam logic [IDX_W-1:0] REG_LON = 3'd1;
  localparam logic [IDX_W-1:0] REG_ALT = 3'd2;
  localparam logic [IDX_W-1:0] REG_SMA = 3'd3;
  localparam logic [IDX_W-1:0] REG_ECC = 3'd4;

  localparam logic signed [39:0] OUT_LIMIT = 40'sd200000000000;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;
  } e2e_cfg_t;

  typedef struct packed {
    logic                  done;
    logic signed [Q_W-1:0] sin;
    logic signed [Q_W-1:0] cos;
  } e2e_sincos_t;

  typedef struct packed {
    logic signed [ST_W-1:0] st_x;
    logic signed [ST_W-1:0] st_y;
    logic signed [ST_W-1:0] st_z;
    logic signed [Q_W-1:0]  sl;
    logic signed [Q_W-1:0]  cl;
    logic signed [Q_W-1:0]  so;
    logic signed [Q_W-1:0]  co;
    logic signed [Q_W-1:0]  clco;
    logic signed [Q_W-1:0]  clso;
    logic signed [Q_W-1:0]  slco;
    logic signed [Q_W-1:0]  slso;
  } e2e_station_t;

  function automatic logic signed [33:0] cordic_atan(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:    v = 34'sd536870912;
      5'd1:    v = 34'sd316933406;
      5'd2:    v = 34'sd167458907;
      5'd3:    v = 34'sd85004756;
      5'd4:    v = 34'sd42667331;
      5'd5:    v = 34'sd21354465;
      5'd6:    v = 34'sd10679839;
      5'd7:    v = 34'sd5340245;
      5'd8:    v = 34'sd2670163;
      5'd9:    v = 34'sd1335087;
      5'd10:   v = 34'sd667544;
      5'd11:   v = 34'sd333772;
      5'd12:   v = 34'sd166886;
      5'd13:   v = 34'sd83443;
      5'd14:   v = 34'sd41722;
      5'd15:   v = 34'sd20861;
      5'd16:   v = 34'sd10430;
      5'd17:   v = 34'sd5215;
      5'd18:   v = 34'sd2608;
      5'd19:   v = 34'sd1304;
      5'd20:   v = 34'sd652;
      5'd21:   v = 34'sd326;
      5'd22:   v = 34'sd163;
      5'd23:   v = 34'sd81;
      5'd24:   v = 34'sd41;
      5'd25:   v = 34'sd20;
      5'd26:   v = 34'sd10;
      5'd27:   v = 34'sd5;
      5'd28:   v = 34'sd3;
      5'd29:   v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/e2e_if.sv -----
interface e2e_target_if;
  logic                                valid;
  logic                                ready;
  logic signed [e2e_pkg::IN_W-1:0]     target_x;
  logic signed [e2e_pkg::IN_W-1:0]     target_y;
  logic signed [e2e_pkg::IN_W-1:0]     target_z;

  modport source (output valid, output target_x, output target_y, output target_z,
                  input ready);
  modport sink   (input valid, input target_x, input target_y, input target_z,
                  output ready);
endinterface

interface e2e_enu_if;
  logic                                valid;
  logic                                ready;
  logic signed [e2e_pkg::OUT_W-1:0]    east_offset;
  logic signed [e2e_pkg::OUT_W-1:0]    north_offset;
  logic signed [e2e_pkg::OUT_W-1:0]    up_offset;

  modport source (output valid, output east_offset, output north_offset,
                  output up_offset, input ready);
  modport sink   (input valid, input east_offset, input north_offset,
                  input up_offset, output ready);
endinterface

// ----- src/e2e_cordic.sv -----
module e2e_cordic (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [e2e_pkg::Q_W-1:0]     angle_i,
  output e2e_pkg::e2e_sincos_t        res_o
);

  localparam int C_W = 34;
  localparam logic signed [32:0] HALF = 33'sd1073741824;
  localparam logic signed [32:0] PI   = 33'sd2147483648;
  localparam logic signed [C_W-1:0] GAIN = 34'sd652032874;
  localparam logic signed [C_W-1:0] ONE  = 34'sd1073741824;
  localparam logic [4:0] LAST = 5'(e2e_pkg::CORDIC_ITERS - 1);

  logic signed [C_W-1:0] x_q, y_q, z_q;
  logic [4:0]            it_q;
  logic                  busy_q, done_q, neg_q;
  logic signed [e2e_pkg::Q_W-1:0] sin_q, cos_q;

  logic signed [32:0]    th;
  logic                  neg_d;
  logic signed [C_W-1:0] sx, sy, at, nx, ny, nz;
  logic signed [C_W-1:0] cx, cy;

  function automatic logic signed [C_W-1:0] clampq(input logic signed [C_W-1:0] v);
    logic signed [C_W-1:0] r;
    if (v > ONE) begin
      r = ONE;
    end else if (v < -ONE) begin
      r = -ONE;
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_comb begin
    th    = 33'(signed'(angle_i));
    neg_d = 1'b0;
    if (th > HALF) begin
      th    = th - PI;
      neg_d = 1'b1;
    end else if (th < -HALF) begin
      th    = th + PI;
      neg_d = 1'b1;
    end
    sx = x_q >>> it_q;
    sy = y_q >>> it_q;
    at = e2e_pkg::cordic_atan(it_q);
    if (z_q >= 0) begin
      nx = x_q - sy;
      ny = y_q + sx;
      nz = z_q - at;
    end else begin
      nx = x_q + sy;
      ny = y_q - sx;
      nz = z_q + at;
    end
    cx = clampq(nx);
    cy = clampq(ny);
    if (neg_q) begin
      cx = -cx;
      cy = -cy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        it_q   <= '0;
      end else if (busy_q) begin
        it_q <= it_q + 5'd1;
        if (it_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= GAIN;
      y_q   <= '0;
      z_q   <= C_W'(th);
      neg_q <= neg_d;
    end else if (busy_q) begin
      x_q <= nx;
      y_q <= ny;
      z_q <= nz;
      if (it_q == LAST) begin
        cos_q <= e2e_pkg::Q_W'(cx);
        sin_q <= e2e_pkg::Q_W'(cy);
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.sin  = sin_q;
  assign res_o.cos  = cos_q;

endmodule

// ----- src/e2e_setup.sv -----
module e2e_setup #(
  parameter int ANGLE_BITS = e2e_pkg::DEF_ANGLE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  e2e_pkg::e2e_cfg_t     cfg_i,
  output e2e_pkg::e2e_station_t station_o,
  output logic                  ready_o
);

  localparam int Q_W  = e2e_pkg::Q_W;
  localparam int ST_W = e2e_pkg::ST_W;

  localparam logic [3:0] ST_LAT   = 4'd0;
  localparam logic [3:0] ST_LAT_W = 4'd1;
  localparam logic [3:0] ST_LON   = 4'd2;
  localparam logic [3:0] ST_LON_W = 4'd3;
  localparam logic [3:0] ST_S2    = 4'd4;
  localparam logic [3:0] ST_WSET  = 4'd5;
  localparam logic [3:0] ST_SQRT  = 4'd6;
  localparam logic [3:0] ST_DIVI  = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_NZ    = 4'd9;
  localparam logic [3:0] ST_H     = 4'd10;
  localparam logic [3:0] ST_ROT   = 4'd11;
  localparam logic [3:0] ST_STP   = 4'd12;
  localparam logic [3:0] ST_STS   = 4'd13;
  localparam logic [3:0] ST_DONE  = 4'd14;

  localparam logic [30:0] W_ONE   = 31'h4000_0000;
  localparam logic [60:0] SQ_TOP  = 61'h1000_0000_0000_0000;
  localparam logic [5:0]  DIV_END = 6'd62;
  localparam logic signed [71:0] ST_RND = 72'sd536870912;

  logic [3:0]                  state_q;
  logic [ANGLE_BITS-1:0]       lat_q, lon_q;
  logic signed [24:0]          alt_q;
  logic [32:0]                 a_q;
  logic [28:0]                 e2_q;

  logic signed [Q_W-1:0]       sl_q, cl_q, so_q, co_q, clco_q, clso_q, slco_q, slso_q;
  logic [30:0]                 s2_q;
  logic [60:0]                 v_q, bit_q;
  logic [61:0]                 res_q;
  logic [30:0]                 r_q;
  logic [31:0]                 rem_q;
  logic [62:0]                 dq_q;
  logic [5:0]                  cnt_q;
  logic [35:0]                 nz_q;
  logic signed [ST_W-1:0]      h_q, hz_q;
  logic signed [48:0]          ph_q [3];
  logic signed [52:0]          pl_q [3];
  logic signed [ST_W-1:0]      st_q [3];

  e2e_pkg::e2e_sincos_t        sc;
  logic                        cd_start;
  logic [Q_W-1:0]              cd_angle;

  logic signed [Q_W-1:0]       s2_full;
  logic [60:0]                 e2s2_t;
  logic [30:0]                 w_d;
  logic [61:0]                 sq_trial;
  logic                        sq_take;
  logic [31:0]                 div_rs;
  logic                        div_take;
  logic [35:0]                 n_w;
  logic [65:0]                 nz_t;
  logic signed [ST_W-1:0]      mq_a [3];
  logic signed [Q_W-1:0]       mq_c [3];
  logic signed [16:0]          mq_ah [3];
  logic signed [71:0]          mq_full [3];

  function automatic logic signed [Q_W-1:0] mulqq(input logic signed [Q_W-1:0] a,
                                                  input logic signed [Q_W-1:0] b);
    logic signed [63:0] p;
    p = a * b;
    p = p + 64'sd536870912;
    return p[61:30];
  endfunction

  assign cd_start = (state_q == ST_LAT) || (state_q == ST_LON);
  assign cd_angle = (state_q == ST_LAT) ? (Q_W'(lat_q) << (Q_W - ANGLE_BITS))
                                        : (Q_W'(lon_q) << (Q_W - ANGLE_BITS));

  e2e_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cd_start),
    .angle_i (cd_angle),
    .res_o   (sc)
  );

  always_comb begin
    s2_full  = mulqq(sl_q, sl_q);
    e2s2_t   = 61'(e2_q) * 61'(s2_q) + (61'(1) << 31);
    w_d      = W_ONE - 31'(e2s2_t[60:32]);
    sq_trial = res_q + 62'(bit_q);
    sq_take  = ({1'b0, v_q} >= sq_trial);
    div_rs   = {rem_q[30:0], dq_q[62]};
    div_take = (div_rs >= {1'b0, r_q});
    n_w      = dq_q[35:0];
    nz_t     = 66'(n_w) * 66'(e2_q) + (66'(1) << 31);
    mq_a[0]  = h_q;
    mq_a[1]  = h_q;
    mq_a[2]  = hz_q;
    mq_c[0]  = clco_q;
    mq_c[1]  = clso_q;
    mq_c[2]  = sl_q;
    for (int k = 0; k < 3; k++) begin
      mq_ah[k]   = 17'(mq_a[k] >>> 20);
      mq_full[k] = (72'(ph_q[k]) <<< 20) + 72'(pl_q[k]) + ST_RND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LAT;
      lat_q   <= '0;
      lon_q   <= '0;
      alt_q   <= '0;
      a_q     <= 33'd6378137000;
      e2_q    <= 29'd28752142;
      cnt_q   <= '0;
    end else if (cfg_i.we) begin
      state_q <= ST_LAT;
      case (cfg_i.index)
        e2e_pkg::REG_LAT: lat_q <= cfg_i.data[31 -: ANGLE_BITS];
        e2e_pkg::REG_LON: lon_q <= cfg_i.data[31 -: ANGLE_BITS];
        e2e_pkg::REG_ALT: alt_q <= signed'(cfg_i.data[24:0]);
        e2e_pkg::REG_SMA: a_q   <= cfg_i.data[32:0];
        e2e_pkg::REG_ECC: e2_q  <= cfg_i.data[28:0];
        default: ;
      endcase
    end else begin
      case (state_q)
        ST_LAT:   state_q <= ST_LAT_W;
        ST_LAT_W: if (sc.done) state_q <= ST_LON;
        ST_LON:   state_q <= ST_LON_W;
        ST_LON_W: if (sc.done) state_q <= ST_S2;
        ST_S2:    state_q <= ST_WSET;
        ST_WSET:  state_q <= ST_SQRT;
        ST_SQRT:  if (bit_q[0]) state_q <= ST_DIVI;
        ST_DIVI: begin
          state_q <= ST_DIV;
          cnt_q   <= '0;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == DIV_END) state_q <= ST_NZ;
        end
        ST_NZ:    state_q <= ST_H;
        ST_H:     state_q <= ST_ROT;
        ST_ROT:   state_q <= ST_STP;
        ST_STP:   state_q <= ST_STS;
        ST_STS:   state_q <= ST_DONE;
        ST_DONE:  state_q <= ST_DONE;
        default:  state_q <= ST_LAT;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LAT_W: if (sc.done) begin
        sl_q <= sc.sin;
        cl_q <= sc.cos;
      end
      ST_LON_W: if (sc.done) begin
        so_q <= sc.sin;
        co_q <= sc.cos;
      end
      ST_S2: s2_q <= 31'(s2_full);
      ST_WSET: begin
        v_q   <= {w_d, 30'd0};
        res_q <= '0;
        bit_q <= SQ_TOP;
      end
      ST_SQRT: begin
        if (sq_take) begin
          v_q   <= v_q - 61'(sq_trial);
          res_q <= (res_q >> 1) + 62'(bit_q);
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_DIVI: begin
        r_q   <= res_q[30:0];
        rem_q <= '0;
        dq_q  <= {a_q, 30'd0} + 63'(res_q[30:1]);
      end
      ST_DIV: begin
        rem_q <= div_take ? (div_rs - {1'b0, r_q}) : div_rs;
        dq_q  <= {dq_q[61:0], div_take};
      end
      ST_NZ: begin
        nz_q <= n_w - 36'(nz_t[65:32]);
        h_q  <= ST_W'(signed'({1'b0, n_w})) + ST_W'(alt_q);
      end
      ST_H: hz_q <= ST_W'(signed'({1'b0, nz_q})) + ST_W'(alt_q);
      ST_ROT: begin
        clco_q <= mulqq(cl_q, co_q);
        clso_q <= mulqq(cl_q, so_q);
        slco_q <= mulqq(sl_q, co_q);
        slso_q <= mulqq(sl_q, so_q);
      end
      ST_STP: begin
        for (int k = 0; k < 3; k++) begin
          ph_q[k] <= mq_ah[k] * mq_c[k];
          pl_q[k] <= signed'({1'b0, mq_a[k][19:0]}) * mq_c[k];
        end
      end
      ST_STS: begin
        for (int k = 0; k < 3; k++) begin
          st_q[k] <= ST_W'(mq_full[k] >>> 30);
        end
      end
      default: ;
    endcase
  end

  assign ready_o        = (state_q == ST_DONE);
  assign station_o.st_x = st_q[0];
  assign station_o.st_y = st_q[1];
  assign station_o.st_z = st_q[2];
  assign station_o.sl   = sl_q;
  assign station_o.cl   = cl_q;
  assign station_o.so   = so_q;
  assign station_o.co   = co_q;
  assign station_o.clco = clco_q;
  assign station_o.clso = clso_q;
  assign station_o.slco = slco_q;
  assign station_o.slso = slso_q;

`ifndef NO_ASSERTIONS
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !cfg_i.we) |=> (state_q == ST_DONE))
    else $error("setup left done without a register write");
  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVI) |-> (res_q != '0))
    else $error("zero radius root");
  a_sin2_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WSET) |-> (s2_q <= W_ONE))
    else $error("sin squared out of range");
`endif

endmodule

// ----- src/e2e_pipe.sv -----
module e2e_pipe #(
  parameter int COORD_BITS = e2e_pkg::DEF_COORD_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  station_ok_i,
  input  e2e_pkg::e2e_station_t station_i,
  e2e_target_if.sink            target_i,
  e2e_enu_if.source             enu_o
);

  localparam int Q_W    = e2e_pkg::Q_W;
  localparam int OUT_W  = e2e_pkg::OUT_W;
  localparam int DIFF_W = (COORD_BITS > 40) ? COORD_BITS : 40;
  localparam int LO_W   = 20;
  localparam int AH_W   = COORD_BITS - LO_W;
  localparam int PH_W   = AH_W + Q_W;
  localparam int PL_W   = LO_W + 1 + Q_W;
  localparam int P_W    = COORD_BITS + Q_W + 2;
  localparam int M_W    = COORD_BITS + 1;
  localparam int SUM_W  = (COORD_BITS + 3 > 40) ? COORD_BITS + 3 : 40;

  localparam logic signed [DIFF_W-1:0] D_MAX = (DIFF_W'(1) <<< (COORD_BITS - 1)) - DIFF_W'(1);
  localparam logic signed [DIFF_W-1:0] D_MIN = -D_MAX - DIFF_W'(1);
  localparam logic signed [P_W-1:0]    RND   = P_W'(536870912);
  localparam logic signed [SUM_W-1:0]  LIM   = SUM_W'(e2e_pkg::OUT_LIMIT);

  logic                          adv;
  logic                          v1_q, v2_q, v3_q, v4_q;
  logic signed [COORD_BITS-1:0]  d_q  [3];
  logic signed [PH_W-1:0]        ph_q [8];
  logic signed [PL_W-1:0]        pl_q [8];
  logic signed [M_W-1:0]         m_q  [8];
  logic signed [OUT_W-1:0]       out_q [3];

  logic signed [DIFF_W-1:0]      tgt [3];
  logic signed [DIFF_W-1:0]      stn [3];
  logic signed [DIFF_W-1:0]      diff [3];
  logic signed [COORD_BITS-1:0]  dsat [3];
  logic signed [COORD_BITS-1:0]  opd [8];
  logic signed [Q_W-1:0]         coef [8];
  logic signed [AH_W-1:0]        ah [8];
  logic signed [P_W-1:0]         full [8];
  logic signed [SUM_W-1:0]       sum [3];
  logic signed [SUM_W-1:0]       ssat [3];

  assign adv            = !v4_q || enu_o.ready;
  assign target_i.ready = station_ok_i && adv;

  always_comb begin
    tgt[0] = DIFF_W'(target_i.target_x);
    tgt[1] = DIFF_W'(target_i.target_y);
    tgt[2] = DIFF_W'(target_i.target_z);
    stn[0] = DIFF_W'(station_i.st_x);
    stn[1] = DIFF_W'(station_i.st_y);
    stn[2] = DIFF_W'(station_i.st_z);
    for (int k = 0; k < 3; k++) begin
      diff[k] = tgt[k] - stn[k];
      if (diff[k] > D_MAX) begin
        dsat[k] = COORD_BITS'(D_MAX);
      end else if (diff[k] < D_MIN) begin
        dsat[k] = COORD_BITS'(D_MIN);
      end else begin
        dsat[k] = COORD_BITS'(diff[k]);
      end
    end

    opd[0] = d_q[0]; coef[0] = station_i.so;
    opd[1] = d_q[1]; coef[1] = station_i.co;
    opd[2] = d_q[0]; coef[2] = station_i.slco;
    opd[3] = d_q[1]; coef[3] = station_i.slso;
    opd[4] = d_q[2]; coef[4] = station_i.cl;
    opd[5] = d_q[0]; coef[5] = station_i.clco;
    opd[6] = d_q[1]; coef[6] = station_i.clso;
    opd[7] = d_q[2]; coef[7] = station_i.sl;
    for (int k = 0; k < 8; k++) begin
      ah[k]   = AH_W'(opd[k] >>> LO_W);
      full[k] = (P_W'(ph_q[k]) <<< LO_W) + P_W'(pl_q[k]) + RND;
    end

    sum[0] = SUM_W'(m_q[1]) - SUM_W'(m_q[0]);
    sum[1] = SUM_W'(m_q[4]) - SUM_W'(m_q[2]) - SUM_W'(m_q[3]);
    sum[2] = SUM_W'(m_q[5]) + SUM_W'(m_q[6]) + SUM_W'(m_q[7]);
    for (int k = 0; k < 3; k++) begin
      if (sum[k] > LIM) begin
        ssat[k] = LIM;
      end else if (sum[k] < -LIM) begin
        ssat[k] = -LIM;
      end else begin
        ssat[k] = sum[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= target_i.valid && target_i.ready;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        d_q[k]   <= dsat[k];
        out_q[k] <= OUT_W'(ssat[k]);
      end
      for (int k = 0; k < 8; k++) begin
        ph_q[k] <= ah[k] * coef[k];
        pl_q[k] <= signed'({1'b0, opd[k][LO_W-1:0]}) * coef[k];
        m_q[k]  <= M_W'(full[k] >>> 30);
      end
    end
  end

  assign enu_o.valid        = v4_q;
  assign enu_o.east_offset  = out_q[0];
  assign enu_o.north_offset = out_q[1];
  assign enu_o.up_offset    = out_q[2];

`ifndef NO_ASSERTIONS
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (target_i.valid && target_i.ready) |=> v1_q)
    else $error("accepted transaction missing from first stage");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !adv) |=> v3_q)
    else $error("stalled stage lost its transaction");
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (SUM_W'(out_q[0]) <= LIM && SUM_W'(out_q[0]) >= -LIM &&
              SUM_W'(out_q[1]) <= LIM && SUM_W'(out_q[1]) >= -LIM &&
              SUM_W'(out_q[2]) <= LIM && SUM_W'(out_q[2]) >= -LIM))
    else $error("result outside saturation range");
`endif

endmodule

// ----- src/ecef_to_local_enu_top.sv -----
// channel    | dir | handshake   | payload
// target_i   | in  | valid/ready | target_x, target_y, target_z (38b signed mm)
// enu_o      | out | valid/ready | east_offset, north_offset, up_offset (39b signed mm)
// cfg        | in  | cfg_we_i    | cfg_index_i (3b), cfg_data_i (33b)
//
// One transaction per cycle through a four-stage multiply pipeline while the output is not stalled.
// The station terms come from an iterative sequencer (shared CORDIC, bit-serial root and
// divider) that runs after reset and again after every register write.
// target_i.ready stays low until that sequence completes.
// A stalled output freezes every stage; nothing is dropped or repeated.
module ecef_to_local_enu_top #(
  parameter int COORD_BITS = e2e_pkg::DEF_COORD_BITS,
  parameter int ANGLE_BITS = e2e_pkg::DEF_ANGLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [e2e_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [e2e_pkg::CFG_W-1:0]     cfg_data_i,
  e2e_target_if.sink                    target_i,
  e2e_enu_if.source                     enu_o
);

  e2e_pkg::e2e_cfg_t     cfg;
  e2e_pkg::e2e_station_t station;
  logic                  station_ok;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  e2e_setup #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_setup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .station_o (station),
    .ready_o   (station_ok)
  );

  e2e_pipe #(
    .COORD_BITS (COORD_BITS)
  ) u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .station_ok_i (station_ok),
    .station_i    (station),
    .target_i     (target_i),
    .enu_o        (enu_o)
  );

endmodule
